// ===== rtl/qst_pkg.sv =====
// ----------------------------------------------------------------------------
// qst_pkg
// Shared types, constants and helpers of the quadrature setpoint thermostat.
// ----------------------------------------------------------------------------
package qst_pkg;

  localparam int unsigned InTdataW  = 16;
  localparam int unsigned OutTdataW = 32;

  localparam logic [7:0] ResetHigh = 8'd80;
  localparam logic [7:0] ResetLow  = 8'd60;
  localparam logic [7:0] FahrOffs  = 8'd32;
  localparam logic [7:0] MaxLimit  = 8'd255;
  localparam logic [7:0] MinLimit  = 8'd0;

  // 9/10 as a fixed-point reciprocal, exact for every 8-bit reading
  localparam int unsigned NineTenthsMul   = 29493;
  localparam int unsigned NineTenthsShift = 15;

  localparam logic [1:0] PhaseA0B0 = 2'd0;
  localparam logic [1:0] PhaseA0B1 = 2'd1;
  localparam logic [1:0] PhaseA1B1 = 2'd2;
  localparam logic [1:0] PhaseA1B0 = 2'd3;

  typedef struct packed {
    logic       enc_a;
    logic       enc_b;
    logic       red_pressed;
    logic       blue_pressed;
    logic [7:0] sensor_whole;
    logic       sensor_half;
  } sample_t;

  typedef struct packed {
    logic [7:0] high_setpoint;
    logic [7:0] low_setpoint;
    logic       setpoint_changed;
  } setpoint_t;

  function automatic logic [1:0] phase_of(input logic a, input logic b);
    logic [1:0] p;
    unique case ({a, b})
      2'b00:   p = PhaseA0B0;
      2'b01:   p = PhaseA0B1;
      2'b11:   p = PhaseA1B1;
      default: p = PhaseA1B0;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] to_fahrenheit(input logic [7:0] whole, input logic half);
    logic [7:0]  t;
    logic [22:0] prod;
    logic [7:0]  q;
    t    = {whole[6:0], half};
    prod = 23'(t) * 23'(NineTenthsMul);
    q    = prod[NineTenthsShift +: 8];
    return q + FahrOffs;
  endfunction

endpackage

// ===== rtl/qst_setpoint.sv =====
// ----------------------------------------------------------------------------
// qst_setpoint
// Button selection, quadrature step decode and bounded setpoint registers.
// ----------------------------------------------------------------------------
module qst_setpoint (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  qst_pkg::sample_t    sample_i,
  output qst_pkg::setpoint_t  result_o,
  output logic [7:0]          high_o,
  output logic [7:0]          low_o
);

  logic [1:0] phase_q, phase_d;
  logic       adj_high_q, adj_high_d;
  logic [7:0] high_q, high_d;
  logic [7:0] low_q, low_d;
  logic       fwd, bwd;

  always_comb begin
    phase_d = qst_pkg::phase_of(sample_i.enc_a, sample_i.enc_b);
    fwd     = (phase_d == phase_q + 2'd1);
    bwd     = (phase_q == phase_d + 2'd1);

    priority if (sample_i.red_pressed) begin
      adj_high_d = 1'b1;
    end else if (sample_i.blue_pressed) begin
      adj_high_d = 1'b0;
    end else begin
      adj_high_d = adj_high_q;
    end

    high_d = high_q;
    low_d  = low_q;
    if (adj_high_d) begin
      if (fwd && high_q != qst_pkg::MaxLimit) begin
        high_d = high_q + 8'd1;
      end else if (bwd && high_q > low_q + 8'd1) begin
        high_d = high_q - 8'd1;
      end
    end else begin
      if (fwd && low_q + 8'd1 < high_q) begin
        low_d = low_q + 8'd1;
      end else if (bwd && low_q != qst_pkg::MinLimit) begin
        low_d = low_q - 8'd1;
      end
    end

    result_o.high_setpoint    = high_d;
    result_o.low_setpoint     = low_d;
    result_o.setpoint_changed = (high_d != high_q) || (low_d != low_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= qst_pkg::PhaseA0B0;
      adj_high_q <= 1'b0;
      high_q     <= qst_pkg::ResetHigh;
      low_q      <= qst_pkg::ResetLow;
    end else if (step_i) begin
      phase_q    <= phase_d;
      adj_high_q <= adj_high_d;
      high_q     <= high_d;
      low_q      <= low_d;
    end
  end

  assign high_o = high_q;
  assign low_o  = low_q;

endmodule

// ===== rtl/quadrature_setpoint_thermostat.sv =====
// ----------------------------------------------------------------------------
// quadrature_setpoint_thermostat
// Encoder-driven thermostat setpoints with Fahrenheit reading and demands.
// ----------------------------------------------------------------------------
// One result per sample request, one request per clock sustained while the
// output is not stalled: a sample is registered, the setpoint update and
// Fahrenheit scaling run combinationally between that input register and the
// result register, and the setpoint state advances as the sample moves into
// the result register. Both stages hold under stall.
module quadrature_setpoint_thermostat (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // enc_a[0] enc_b[1] red_pressed[2] blue_pressed[3] sensor_whole[11:4]
  // sensor_half[12], zero [15:13]
  input  logic [qst_pkg::InTdataW-1:0]   s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // fahrenheit[7:0] high_setpoint[15:8] low_setpoint[23:16] cool_on[24]
  // heat_on[25] setpoint_changed[26], zero [31:27]
  output logic [qst_pkg::OutTdataW-1:0]  m_axis_tdata
);

  logic               in_vld_q;
  qst_pkg::sample_t   in_q;
  logic               out_vld_q;
  logic [31:0]        out_q, out_d;
  logic               advance;
  qst_pkg::setpoint_t sp;
  logic [7:0]         fahr;
  logic [7:0]         high_cur, low_cur;

  assign advance       = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || advance;

  qst_setpoint u_setpoint (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (in_vld_q && advance),
    .sample_i (in_q),
    .result_o (sp),
    .high_o   (high_cur),
    .low_o    (low_cur)
  );

  always_comb begin
    fahr  = qst_pkg::to_fahrenheit(in_q.sensor_whole, in_q.sensor_half);
    out_d = {5'd0, sp.setpoint_changed, (sp.low_setpoint > fahr),
             (sp.high_setpoint < fahr), sp.low_setpoint, sp.high_setpoint, fahr};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q.enc_a        <= s_axis_tdata[0];
      in_q.enc_b        <= s_axis_tdata[1];
      in_q.red_pressed  <= s_axis_tdata[2];
      in_q.blue_pressed <= s_axis_tdata[3];
      in_q.sensor_whole <= s_axis_tdata[11:4];
      in_q.sensor_half  <= s_axis_tdata[12];
    end
    if (in_vld_q && advance) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  // setpoint ordering holds in every cycle
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    high_cur > low_cur)
    else $error("high setpoint not above low setpoint");

  // cooling and heating never requested together
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[24] && m_axis_tdata[25]))
    else $error("cool and heat both on");

  // a result shown carries the current setpoints
  a_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[15:8] == high_cur && m_axis_tdata[23:16] == low_cur))
    else $error("result setpoints differ from state");

  // stage with no pending result can always take a request
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule
